[sv/wmsel_pkg.sv]
`default_nettype none

package wmsel_pkg;

  localparam logic [3:0] KMER_LENGTH_RESET = 4'd8;
  localparam logic [15:0] RANK_ALL_ONES = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int STORE_DEPTH = 65536;
  localparam int STORE_ADDR_W = 16;
  localparam int RANK_W = 16;

  localparam logic [7:0] CHAR_A_UPPER = 8'h41;
  localparam logic [7:0] CHAR_C_UPPER = 8'h43;
  localparam logic [7:0] CHAR_G_UPPER = 8'h47;
  localparam logic [7:0] CHAR_T_UPPER = 8'h54;
  localparam logic [7:0] CHAR_A_LOWER = 8'h61;
  localparam logic [7:0] CHAR_C_LOWER = 8'h63;
  localparam logic [7:0] CHAR_G_LOWER = 8'h67;
  localparam logic [7:0] CHAR_T_LOWER = 8'h74;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic        is_seq;
    logic        last;
    logic        complete;
    logic        first;
    logic        is_short;
    logic [15:0] addr;
    logic [15:0] rank;
    logic [5:0]  end_pos;
  } op_t;

  typedef struct packed {
    logic        we;
    logic        re;
    logic [15:0] addr;
    logic [15:0] wdata;
  } ram_req_t;

  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [1:0] code;
    unique case (ch)
      CHAR_A_UPPER, CHAR_A_LOWER: code = BASE_A;
      CHAR_C_UPPER, CHAR_C_LOWER: code = BASE_C;
      CHAR_G_UPPER, CHAR_G_LOWER: code = BASE_G;
      CHAR_T_UPPER, CHAR_T_LOWER: code = BASE_T;
      default: code = BASE_A;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[sv/wmsel_in_if.sv]
`default_nettype none

interface wmsel_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  symbol;
  logic        last;
  logic [15:0] table_index;
  logic [15:0] table_rank;

  modport source (output valid, mode, symbol, last, table_index, table_rank, input ready);
  modport sink (input valid, mode, symbol, last, table_index, table_rank, output ready);
endinterface

`default_nettype wire

[sv/wmsel_out_if.sv]
`default_nettype none

interface wmsel_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] minimizer_code;
  logic [5:0]  end_position;
  logic        window_short;

  modport source (output valid, minimizer_code, end_position, window_short, input ready);
  modport sink (input valid, minimizer_code, end_position, window_short, output ready);
endinterface

`default_nettype wire

[sv/wmsel_ram.sv]
`default_nettype none

module wmsel_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/wmsel_fifo.sv]
`default_nettype none

module wmsel_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire wmsel_pkg::op_t push_op,
  output logic                full,
  input  wire logic           pop,
  output wmsel_pkg::op_t      head_op,
  output logic                head_valid
);

  wmsel_pkg::op_t entries [wmsel_pkg::QUEUE_DEPTH];
  logic [wmsel_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [wmsel_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [wmsel_pkg::QUEUE_CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full       = (count == wmsel_pkg::QUEUE_CNT_W'(wmsel_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/wmsel_front.sv]
`default_nettype none

module wmsel_front #(
  parameter int K_MAX = 8,
  parameter int W_MAX = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [3:0] kmer_length,
  wmsel_in_if.sink        feed,
  input  wire logic       queue_full,
  output logic            push,
  output wmsel_pkg::op_t  push_op
);

  localparam int CODE_W = 2 * K_MAX;
  localparam int CNT_W  = $clog2(W_MAX + 1);

  logic [CODE_W-1:0] rolling_code;
  logic [CODE_W-1:0] rolling_next;
  logic [CODE_W-1:0] code_mask;
  logic [CNT_W-1:0]  char_count;
  logic [CNT_W-1:0]  char_count_next;
  logic [4:0]        k_eff;
  logic [5:0]        shamt;
  logic [31:0]       code_ext;
  logic [31:0]       cnt_ext;
  logic [31:0]       cnt_after;
  logic [31:0]       end_ext;
  logic              accept;

  assign feed.ready = !queue_full;
  assign accept     = feed.valid && !queue_full;
  assign push       = accept;

  always_comb begin
    if (kmer_length == 4'd0) begin
      k_eff = 5'd1;
    end else if ({1'b0, kmer_length} > 5'(K_MAX)) begin
      k_eff = 5'(K_MAX);
    end else begin
      k_eff = {1'b0, kmer_length};
    end
  end

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      code_mask[2*i +: 2] = (i < int'(k_eff)) ? 2'b11 : 2'b00;
    end
  end

  // The newest base enters at the top of the current k-mer; the oldest drops out below.
  assign shamt        = {k_eff - 5'd1, 1'b0};
  assign rolling_next = ((rolling_code >> 2)
                        | (CODE_W'(wmsel_pkg::base_code(feed.symbol)) << shamt)) & code_mask;
  assign code_ext     = 32'(rolling_next);
  assign cnt_ext      = 32'(char_count);
  assign cnt_after    = (cnt_ext < 32'(W_MAX)) ? cnt_ext + 32'd1 : cnt_ext;
  assign end_ext      = (cnt_ext < 32'(W_MAX - 1)) ? cnt_ext : 32'(W_MAX - 1);

  always_comb begin
    push_op = '0;
    if (feed.mode) begin
      push_op.is_seq   = 1'b1;
      push_op.last     = feed.last;
      push_op.complete = (cnt_ext + 32'd1 >= 32'(k_eff));
      push_op.first    = (cnt_ext + 32'd1 == 32'(k_eff));
      push_op.is_short = (cnt_after < 32'(k_eff));
      push_op.addr     = code_ext[15:0];
      push_op.end_pos  = end_ext[5:0];
    end else begin
      push_op.addr = feed.table_index;
      push_op.rank = feed.table_rank;
    end
  end

  assign char_count_next = feed.last ? '0 : cnt_after[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rolling_code <= '0;
      char_count   <= '0;
    end else if (accept && feed.mode) begin
      rolling_code <= feed.last ? '0 : rolling_next;
      char_count   <= char_count_next;
    end
  end

endmodule

`default_nettype wire

[sv/wmsel_back.sv]
`default_nettype none

module wmsel_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire wmsel_pkg::op_t   head_op,
  input  wire logic             head_valid,
  output logic                  pop,
  output wmsel_pkg::ram_req_t   ram_req,
  input  wire logic [15:0]      ram_rdata,
  wmsel_out_if.source           result
);

  wmsel_pkg::op_t op;
  logic           op_valid;
  logic           advance;
  logic           take;
  logic [15:0]    best_code;
  logic [15:0]    best_rank;
  logic [5:0]     best_end;
  logic [15:0]    best_code_next;
  logic [15:0]    best_rank_next;
  logic [5:0]     best_end_next;
  logic           emit;

  // The rank lookup stage stalls only when it holds a window's final item and the
  // output register is still occupied.
  assign advance = !(op_valid && op.is_seq && op.last && result.valid && !result.ready);
  assign pop     = advance && head_valid;

  always_comb begin
    ram_req       = '0;
    ram_req.addr  = head_op.addr;
    ram_req.wdata = head_op.rank;
    ram_req.we    = pop && !head_op.is_seq;
    ram_req.re    = pop && head_op.is_seq && head_op.complete;
  end

  assign take = op.complete && (op.first || ram_rdata < best_rank);
  assign best_code_next = take ? op.addr : best_code;
  assign best_rank_next = take ? ram_rdata : best_rank;
  assign best_end_next  = take ? op.end_pos : best_end;
  assign emit = op_valid && advance && op.is_seq && op.last;

  always_ff @(posedge clk) begin
    if (advance) begin
      op <= head_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid  <= 1'b0;
      best_code <= '0;
      best_rank <= wmsel_pkg::RANK_ALL_ONES;
      best_end  <= '0;
    end else begin
      if (advance) begin
        op_valid <= head_valid;
      end
      if (op_valid && advance && op.is_seq) begin
        if (op.last) begin
          best_code <= '0;
          best_rank <= wmsel_pkg::RANK_ALL_ONES;
          best_end  <= '0;
        end else begin
          best_code <= best_code_next;
          best_rank <= best_rank_next;
          best_end  <= best_end_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.minimizer_code <= op.is_short ? 16'd0 : best_code_next;
      result.end_position   <= op.is_short ? 6'd0 : best_end_next;
      result.window_short   <= op.is_short;
    end
  end

endmodule

`default_nettype wire

[sv/window_minimizer_select_unit.sv]
`default_nettype none

// Minimizer selection for one window of bases. Items on feed either load one rank
// table entry (mode 0) or carry one base character (mode 1); the base item marked last
// closes the window and yields one result on the result channel. The block takes one
// item per clock while the queue is not full: the front keeps the rolling k-mer code
// and position counter and classifies each item, a four-entry queue decouples it from
// the back, which does at most one rank table access per item in a 64K x 16 memory
// and the compare against the best rank so far. A result passes through the queue, the
// lookup stage register and the output register; a full queue or an unclaimed result
// stops intake. The rank table is not cleared at reset and entries must be loaded
// before a window uses them. kmer_length may be written only while the block is idle.
module window_minimizer_select_unit #(
  parameter int K_MAX = 8,
  parameter int W_MAX = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic [3:0] cfg_write_data,
  wmsel_in_if.sink        feed,
  wmsel_out_if.source     result
);

  logic [3:0]          kmer_length;
  logic                push;
  wmsel_pkg::op_t      push_op;
  logic                queue_full;
  logic                pop;
  wmsel_pkg::op_t      head_op;
  logic                head_valid;
  wmsel_pkg::ram_req_t ram_req;
  logic [15:0]         ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= wmsel_pkg::KMER_LENGTH_RESET;
    end else if (cfg_write_en) begin
      kmer_length <= cfg_write_data;
    end
  end

  wmsel_front #(
    .K_MAX(K_MAX),
    .W_MAX(W_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .kmer_length(kmer_length),
    .feed       (feed),
    .queue_full (queue_full),
    .push       (push),
    .push_op    (push_op)
  );

  wmsel_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (queue_full),
    .pop       (pop),
    .head_op   (head_op),
    .head_valid(head_valid)
  );

  wmsel_ram #(
    .WIDTH(wmsel_pkg::RANK_W),
    .DEPTH(wmsel_pkg::STORE_DEPTH)
  ) u_rank_store (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.addr),
    .wdata(ram_req.wdata),
    .re   (ram_req.re),
    .raddr(ram_req.addr),
    .rdata(ram_rdata)
  );

  wmsel_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_op   (head_op),
    .head_valid(head_valid),
    .pop       (pop),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .result    (result)
  );

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_BASE = 1'b1;
  localparam int KMER_MAX = 8;
  localparam int WINDOW_MAX = 64;
  localparam int ITEM_TARGET = 850;
  localparam int WINDOW_TARGET = 20;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic        mode;
    logic [7:0]  symbol;
    logic        last;
    logic [15:0] table_index;
    logic [15:0] table_rank;
  } feed_item_t;

  typedef struct {
    logic [15:0] code;
    logic [5:0]  end_pos;
    logic        short_flag;
  } minimizer_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [3:0] cfg_write_data;

  wmsel_in_if feed_if ();
  wmsel_out_if result_if ();

  window_minimizer_select_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .feed(feed_if),
    .result(result_if)
  );

  // Predictor state, updated in the order the block accepts items.
  logic [15:0] rank_mem [0:65535];
  bit rank_loaded [0:65535];
  logic [15:0] roll_state;
  logic [15:0] kept_code;
  logic [15:0] kept_rank;
  logic [5:0]  kept_end;
  int          window_count;
  logic [3:0]  kmer_len_reg;

  minimizer_t expected_minimizers[$];

  int fail_count = 0;
  int items_sent = 0;
  int windows_sent = 0;
  int cycle_count = 0;
  int rank_style = 0;
  bit noise_on = 1'b0;
  bit feed_idle_on = 1'b1;
  bit result_stall_on = 1'b1;

  logic [7:0] acgt_chars [0:7];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [1:0] base_of(input logic [7:0] sym);
    case (sym)
      wmsel_pkg::CHAR_C_UPPER, wmsel_pkg::CHAR_C_LOWER: return wmsel_pkg::BASE_C;
      wmsel_pkg::CHAR_G_UPPER, wmsel_pkg::CHAR_G_LOWER: return wmsel_pkg::BASE_G;
      wmsel_pkg::CHAR_T_UPPER, wmsel_pkg::CHAR_T_LOWER: return wmsel_pkg::BASE_T;
      default: return wmsel_pkg::BASE_A;
    endcase
  endfunction

  function automatic int eff_k(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > KMER_MAX) return KMER_MAX;
    return int'(v);
  endfunction

  // The newest base enters at the top of the k-mer, the oldest leaves at the bottom.
  function automatic logic [15:0] roll_code(input logic [15:0] prev, input logic [7:0] sym,
                                            input int k);
    logic [31:0] w;
    w = ({16'b0, prev} >> 2) | ({30'b0, base_of(sym)} << (2 * (k - 1)));
    w = w & ((32'd1 << (2 * k)) - 32'd1);
    return w[15:0];
  endfunction

  function automatic logic [15:0] pick_rank();
    case (rank_style)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 3));
      default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [7:0] pick_symbol(input int style);
    int r;
    r = $urandom_range(0, 99);
    case (style)
      0: begin
        if (r < 5) return 8'($urandom_range(0, 255));
        return acgt_chars[$urandom_range(0, 7)];
      end
      // A narrow alphabet repeats k-mers, so equal ranks turn up often.
      1: begin
        if (r < 40) return wmsel_pkg::CHAR_A_UPPER;
        if (r < 70) return wmsel_pkg::CHAR_A_LOWER;
        return wmsel_pkg::CHAR_C_UPPER;
      end
      default: begin
        if (r < 30) return 8'($urandom_range(0, 255));
        return acgt_chars[$urandom_range(0, 7)];
      end
    endcase
  endfunction

  function automatic int pick_window_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 12);
    if (r < 90) return $urandom_range(13, 40);
    return $urandom_range(60, 90);
  endfunction

  task automatic clear_window_state();
    roll_state = 16'h0000;
    kept_code = 16'h0000;
    kept_rank = wmsel_pkg::RANK_ALL_ONES;
    kept_end = 6'd0;
    window_count = 0;
  endtask

  task automatic predict_item(input feed_item_t it);
    int k;
    int pos;
    logic [15:0] r;
    minimizer_t m;
    if (it.mode == MODE_LOAD) begin
      rank_mem[it.table_index] = it.table_rank;
      rank_loaded[it.table_index] = 1'b1;
      return;
    end
    k = eff_k(kmer_len_reg);
    roll_state = roll_code(roll_state, it.symbol, k);
    pos = window_count;
    if (pos + 1 >= k) begin
      r = rank_mem[roll_state];
      if (pos == k - 1 || r < kept_rank) begin
        kept_code = roll_state;
        kept_rank = r;
        kept_end = (pos < WINDOW_MAX - 1) ? 6'(pos) : 6'(WINDOW_MAX - 1);
      end
    end
    if (window_count < WINDOW_MAX) window_count++;
    if (it.last) begin
      m.short_flag = (window_count < k);
      m.code = m.short_flag ? 16'h0000 : kept_code;
      m.end_pos = m.short_flag ? 6'd0 : kept_end;
      expected_minimizers.insert(expected_minimizers.size(), m);
      windows_sent++;
      clear_window_state();
    end
  endtask

  task automatic send_item(input feed_item_t it);
    int gap;
    gap = pick_gap(feed_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      feed_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    feed_if.mode = it.mode;
    feed_if.symbol = it.symbol;
    feed_if.last = it.last;
    feed_if.table_index = it.table_index;
    feed_if.table_rank = it.table_rank;
    feed_if.valid = 1'b1;
    @(posedge clk);
    while (!feed_if.ready) @(posedge clk);
    items_sent++;
    predict_item(it);
  endtask

  task automatic send_load(input logic [15:0] idx, input logic [15:0] rank);
    feed_item_t it;
    it.mode = MODE_LOAD;
    it.symbol = 8'($urandom_range(0, 255));
    it.last = 1'($urandom_range(0, 1));
    it.table_index = idx;
    it.table_rank = rank;
    send_item(it);
  endtask

  // Loads the rank of the k-mer this base completes if it has never been loaded.
  task automatic send_base(input logic [7:0] sym, input logic last);
    feed_item_t it;
    logic [15:0] nxt;
    int k;
    if (noise_on && $urandom_range(0, 99) < 8)
      send_load(16'($urandom_range(0, 65535)), pick_rank());
    k = eff_k(kmer_len_reg);
    nxt = roll_code(roll_state, sym, k);
    if (window_count + 1 >= k && !rank_loaded[nxt]) send_load(nxt, pick_rank());
    it.mode = MODE_BASE;
    it.symbol = sym;
    it.last = last;
    it.table_index = 16'($urandom_range(0, 65535));
    it.table_rank = 16'($urandom_range(0, 65535));
    send_item(it);
  endtask

  task automatic send_bases(input string s);
    for (int i = 0; i < s.len(); i++) send_base(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    feed_if.valid = 1'b0;
    while (expected_minimizers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_kmer_length(input logic [3:0] v);
    wait_drained();
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_write_data = v;
    @(negedge clk);
    cfg_write_en = 1'b0;
    kmer_len_reg = v;
  endtask

  task automatic run_window(input int sym_style);
    int len;
    len = pick_window_len();
    for (int i = 0; i < len; i++) send_base(pick_symbol(sym_style), i == len - 1);
  endtask

  // k is still at its reset value of 8, so five bases make a short window.
  task automatic test_short_window();
    send_bases("ACGTa");
  endtask

  task automatic test_single_base_kmers();
    set_kmer_length(4'd1);
    send_load(16'd0, 16'd7);
    send_load(16'd1, 16'd7);
    send_load(16'd2, 16'd0);
    send_load(16'd3, 16'd0);
    // C is taken first, A only ties, g wins, t ties, and X counts as A.
    send_bases("cAgtX");
  endtask

  task automatic test_kmer_length_zero();
    set_kmer_length(4'd0);
    send_load(16'd3, 16'hFFFF);
    send_bases("t");
  endtask

  task automatic test_kmer_length_above_max();
    set_kmer_length(4'd15);
    send_load(16'hFFFF, 16'd0);
    send_bases("TTTTTTTTt");
  endtask

  task automatic test_drain_pause();
    rank_style = 0;
    repeat (4) begin
      run_window(0);
      wait_drained();
    end
  endtask

  task automatic test_random_phases();
    int n;
    while (items_sent < ITEM_TARGET || windows_sent < WINDOW_TARGET) begin
      set_kmer_length(4'($urandom_range(0, 15)));
      rank_style = $urandom_range(0, 2);
      feed_idle_on = ($urandom_range(0, 3) != 0);
      result_stall_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(2, 6);
      repeat (n) run_window($urandom_range(0, 2));
    end
    feed_idle_on = 1'b1;
    result_stall_on = 1'b1;
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_if.ready = 1'b0;
        stall_left--;
      end else begin
        result_if.ready = 1'b1;
        if (result_stall_on && $urandom_range(0, 99) < 20) stall_left = pick_gap(1'b1);
      end
    end
  end

  always @(posedge clk) begin
    minimizer_t m;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_minimizers.size() == 0) begin
        $error("result item arrived with no expectation waiting");
        fail_count++;
      end else begin
        m = expected_minimizers.pop_front();
        if (result_if.minimizer_code !== m.code) begin
          $error("minimizer_code expected %h actual %h", m.code, result_if.minimizer_code);
          fail_count++;
        end
        if (result_if.end_position !== m.end_pos) begin
          $error("end_position expected %0d actual %0d", m.end_pos, result_if.end_position);
          fail_count++;
        end
        if (result_if.window_short !== m.short_flag) begin
          $error("window_short expected %b actual %b", m.short_flag, result_if.window_short);
          fail_count++;
        end
      end
    end
  end

  initial begin
    acgt_chars[0] = wmsel_pkg::CHAR_A_UPPER;
    acgt_chars[1] = wmsel_pkg::CHAR_C_UPPER;
    acgt_chars[2] = wmsel_pkg::CHAR_G_UPPER;
    acgt_chars[3] = wmsel_pkg::CHAR_T_UPPER;
    acgt_chars[4] = wmsel_pkg::CHAR_A_LOWER;
    acgt_chars[5] = wmsel_pkg::CHAR_C_LOWER;
    acgt_chars[6] = wmsel_pkg::CHAR_G_LOWER;
    acgt_chars[7] = wmsel_pkg::CHAR_T_LOWER;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = 4'd0;
    feed_if.valid = 1'b0;
    feed_if.mode = MODE_LOAD;
    feed_if.symbol = 8'd0;
    feed_if.last = 1'b0;
    feed_if.table_index = 16'd0;
    feed_if.table_rank = 16'd0;
    kmer_len_reg = wmsel_pkg::KMER_LENGTH_RESET;
    clear_window_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_short_window();
    test_single_base_kmers();
    test_kmer_length_zero();
    test_kmer_length_above_max();
    noise_on = 1'b1;
    test_drain_pause();
    test_random_phases();

    wait_drained();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/wmsel_pkg.sv
sv/wmsel_in_if.sv
sv/wmsel_out_if.sv
sv/wmsel_ram.sv
sv/wmsel_fifo.sv
sv/wmsel_front.sv
sv/wmsel_back.sv
sv/window_minimizer_select_unit.sv
tb/tb_top.sv
